// ===== design/sas_pkg.sv =====
package sas_pkg;

  localparam int SAS_NUM_SLOTS = 32;
  localparam int SLOT_W        = 6;
  localparam int IN_DATA_W     = 72;
  localparam int IN_USER_W     = 2;
  localparam int OUT_DATA_W    = 32;
  localparam int CFG_DATA_W    = 16;

  localparam logic [7:0] RUN_FOREVER = 8'd255;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  typedef enum logic {
    CFG_FREEZE = 1'b0,
    CFG_GDELAY = 1'b1
  } cfg_idx_t;

  // One slot of the animation table, stored as a single memory word.
  typedef struct packed {
    logic [7:0]         run_count;
    logic [7:0]         repeat_default;
    logic signed [15:0] first_frame;
    logic signed [15:0] final_frame;
    logic signed [15:0] frame_counter;
    logic [14:0]        delay_reload;
    logic signed [16:0] delay_counter;
    logic               reverse_mode;
  } slot_rec_t;

  function automatic slot_rec_t slot_reset_val();
    slot_rec_t r;
    r.run_count      = '0;
    r.repeat_default = '0;
    r.first_frame    = 16'sh FFFF;
    r.final_frame    = '0;
    r.frame_counter  = '0;
    r.delay_reload   = '0;
    r.delay_counter  = '0;
    r.reverse_mode   = 1'b0;
    return r;
  endfunction

  function automatic logic slot_is_active(slot_rec_t r);
    return (r.run_count != 8'd0) && (r.first_frame != 16'shFFFF)
        && (r.final_frame != 16'shFFFF);
  endfunction

endpackage

// ===== design/sprite_animation_sequencer.sv =====
// A load, start or stop reads its slot from the memory and then registers its
// result once the output register is free. A tick over N slots reads the first
// slot, then registers one result per cycle while the output does not stall,
// and the next request is accepted once the last result has been registered.
// Reset (rst_n low, synchronous) marks every slot as holding its reset value
// and restores freeze to 0 and the global delay setting to 2.
module sprite_animation_sequencer
  import sas_pkg::*;
#(
  parameter int NUM_SLOTS = SAS_NUM_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // slot_index[5:0], range_last[11:6], start_frame[27:12], end_frame[43:28],
  // frame_delay[58:44], repeat_count[66:59], run_reverse[67], zero pad[71:68]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  // Result channel.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_slot[5:0], active[6], frame[22:7], repeats_left[30:23], zero pad[31]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Address width of the slot table; at least one bit for a one-slot table.
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SLOT_W:0] NUM_SLOTS_X = (SLOT_W+1)'(NUM_SLOTS);
  localparam logic [AW-1:0]   LAST_SLOT   = AW'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_PROC = 2'b10
  } state_t;

  // Input fields.
  req_t               in_type;
  logic [SLOT_W-1:0]  in_slot;
  logic [SLOT_W-1:0]  in_last_slot;

  assign in_type      = req_t'(in_tuser[1:0]);
  assign in_slot      = in_tdata[5:0];
  assign in_last_slot = in_tdata[11:6];

  // Configuration registers.
  logic               freeze_r;
  logic signed [15:0] gdelay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freeze_r <= 1'b0;
      gdelay_r <= 16'sd2;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FREEZE: freeze_r <= cfg_wdata[0];
        CFG_GDELAY: gdelay_r <= $signed(cfg_wdata);
        default:    ;
      endcase
    end
  end

  // Control state.
  state_t          state_r, state_nxt;
  logic [AW-1:0]   cur_r, cur_nxt;
  logic [AW-1:0]   end_r, end_nxt;
  logic            out_tvalid_r, out_tvalid_nxt;

  // Request payload, held for the whole transaction.
  req_t               req_type_r;
  logic signed [15:0] req_start_r;
  logic signed [15:0] req_end_r;
  logic [14:0]        req_delay_r;
  logic [7:0]         req_repeat_r;
  logic               req_reverse_r;

  // Result register.
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                  out_tlast_r, out_tlast_nxt;

  // Slot memory with a valid bit per entry; an entry never written reads
  // as the reset value of a slot.
  slot_rec_t       slot_mem [NUM_SLOTS];
  logic            valid_r  [NUM_SLOTS];
  slot_rec_t       rd_data_r;
  logic            rd_vld_r;
  logic            mem_re;
  logic [AW-1:0]   mem_ra;
  logic            mem_we;
  slot_rec_t       mem_wd;

  // Request decode at acceptance.
  logic              in_fire;
  logic              tick_req;
  logic [SLOT_W-1:0] range_lo, range_hi;
  logic [AW-1:0]     first_addr, last_addr;
  logic              slot_in_table;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign tick_req  = (in_type == REQ_TICK);

  always_comb begin
    if (in_slot > in_last_slot) begin
      range_lo = in_last_slot;
      range_hi = in_slot;
    end else begin
      range_lo = in_slot;
      range_hi = in_last_slot;
    end
    first_addr = ({1'b0, range_lo} >= NUM_SLOTS_X) ? '0 : range_lo[AW-1:0];
    last_addr  = ({1'b0, range_hi} >= NUM_SLOTS_X) ? LAST_SLOT : range_hi[AW-1:0];
    slot_in_table = ({1'b0, in_slot} < NUM_SLOTS_X);
  end

  // Read, modify and write back of the current slot.
  logic               can_emit;
  logic               proc_fire;
  slot_rec_t          cur_rec;
  slot_rec_t          new_rec;
  logic               res_active;
  logic signed [15:0] res_frame;
  logic [7:0]         start_runs;
  logic signed [17:0] reload_sum;

  assign can_emit  = !out_tvalid_r || out_tready;
  assign proc_fire = (state_r == S_PROC) && can_emit;
  assign cur_rec   = rd_vld_r ? rd_data_r : slot_reset_val();

  always_comb begin
    new_rec    = cur_rec;
    res_active = 1'b0;
    res_frame  = cur_rec.frame_counter;
    start_runs = (req_repeat_r != 8'd0) ? req_repeat_r : cur_rec.repeat_default;
    reload_sum = 18'(signed'({3'b000, cur_rec.delay_reload}))
               + 18'(gdelay_r) - 18'sd2;
    unique case (req_type_r)
      REQ_LOAD: begin
        new_rec.first_frame    = req_start_r;
        new_rec.final_frame    = req_end_r;
        new_rec.delay_reload   = req_delay_r;
        new_rec.repeat_default = req_repeat_r;
        new_rec.frame_counter  = req_start_r;
        new_rec.delay_counter  = '0;
        new_rec.run_count      = '0;
        new_rec.reverse_mode   = 1'b0;
        res_active = slot_is_active(new_rec);
        res_frame  = new_rec.frame_counter;
      end
      REQ_START: begin
        new_rec.run_count     = start_runs;
        new_rec.reverse_mode  = req_reverse_r;
        new_rec.frame_counter = req_reverse_r ? cur_rec.final_frame
                                              : cur_rec.first_frame;
        res_active = slot_is_active(new_rec);
        res_frame  = new_rec.frame_counter;
      end
      REQ_STOP: begin
        new_rec.run_count = '0;
        res_active = slot_is_active(new_rec);
        res_frame  = new_rec.frame_counter;
      end
      REQ_TICK: begin
        // The frame shown is the one before stepping.
        res_active = slot_is_active(cur_rec);
        res_frame  = cur_rec.frame_counter;
        if (!res_active) begin
          new_rec.run_count = '0;
        end else if (!freeze_r) begin
          if (cur_rec.delay_counter > 17'sd0) begin
            new_rec.delay_counter = cur_rec.delay_counter - 17'sd1;
          end else begin
            // A negative counter counts as run out as well.
            new_rec.delay_counter = reload_sum[16:0];
            if (cur_rec.reverse_mode) begin
              if (cur_rec.frame_counter > cur_rec.first_frame) begin
                new_rec.frame_counter = cur_rec.frame_counter - 16'sd1;
              end else begin
                new_rec.frame_counter = cur_rec.final_frame;
                if (cur_rec.run_count != RUN_FOREVER)
                  new_rec.run_count = cur_rec.run_count - 8'd1;
              end
            end else begin
              if (cur_rec.frame_counter < cur_rec.final_frame) begin
                new_rec.frame_counter = cur_rec.frame_counter + 16'sd1;
              end else begin
                new_rec.frame_counter = cur_rec.first_frame;
                if (cur_rec.run_count != RUN_FOREVER)
                  new_rec.run_count = cur_rec.run_count - 8'd1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Sequencing: while the output does not stall, one slot is written back and
  // reported per cycle, while the next slot of a tick range is read from the
  // memory in the same cycle. The addresses differ, so no forwarding is needed.
  logic is_last_slot;

  assign is_last_slot = (req_type_r != REQ_TICK) || (cur_r == end_r);

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    end_nxt        = end_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    mem_re         = 1'b0;
    mem_ra         = cur_r;
    mem_we         = 1'b0;
    mem_wd         = new_rec;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (tick_req) begin
            cur_nxt   = first_addr;
            end_nxt   = last_addr;
            mem_re    = 1'b1;
            mem_ra    = first_addr;
            state_nxt = S_PROC;
          end else if (slot_in_table) begin
            cur_nxt   = in_slot[AW-1:0];
            end_nxt   = in_slot[AW-1:0];
            mem_re    = 1'b1;
            mem_ra    = in_slot[AW-1:0];
            state_nxt = S_PROC;
          end
          // A load, start or stop outside the table is dropped silently.
        end
      end
      S_PROC: begin
        if (proc_fire) begin
          mem_we         = 1'b1;
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {1'b0, new_rec.run_count,
                            (res_active ? res_frame : 16'shFFFF),
                            res_active, SLOT_W'(cur_r)};
          out_tlast_nxt  = is_last_slot;
          if (is_last_slot) begin
            state_nxt = S_IDLE;
          end else begin
            cur_nxt   = cur_r + AW'(1);
            mem_re    = 1'b1;
            mem_ra    = cur_r + AW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      cur_r        <= '0;
      end_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      cur_r        <= cur_nxt;
      end_r        <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
    if (in_fire) begin
      req_type_r    <= in_type;
      req_start_r   <= $signed(in_tdata[27:12]);
      req_end_r     <= $signed(in_tdata[43:28]);
      req_delay_r   <= in_tdata[58:44];
      req_repeat_r  <= in_tdata[66:59];
      req_reverse_r <= in_tdata[67];
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we)
      slot_mem[cur_r] <= mem_wd;
    if (mem_re)
      rd_data_r <= slot_mem[mem_ra];
  end

  // Valid bits and the valid flag that travels with the read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++)
        valid_r[i] <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we)
        valid_r[cur_r] <= 1'b1;
      if (mem_re)
        rd_vld_r <= valid_r[mem_ra];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

// ===== bench/tb_sprite_animation_sequencer.sv =====
module tb_sprite_animation_sequencer;
  import sas_pkg::*;

  // The watchdog ends the run after this many cycles without any transaction.
  localparam int QUIET_LIMIT = 5000;
  // Long enough for a tick that walks the whole table, plus the pipeline.
  localparam int SETTLE_CYCLES = SAS_NUM_SLOTS + 8;

  // One request as the sender sees it.
  typedef struct packed {
    req_t               kind;
    logic [5:0]         slot;
    logic [5:0]         range_end;
    logic signed [15:0] first_fr;
    logic signed [15:0] last_fr;
    logic [14:0]        delay;
    logic [7:0]         repeats;
    logic               reverse;
  } anim_req_t;

  // One slot report as it leaves the block.
  typedef struct packed {
    logic [5:0]         slot;
    logic               live;
    logic signed [15:0] frame;
    logic [7:0]         repeats;
    logic               last;
  } frame_report_t;

  // A row of the directed script. When typed is set, the report in want is
  // what the block must return, and the predictor only keeps its state.
  typedef struct packed {
    anim_req_t     rq;
    logic          typed;
    frame_report_t want;
  } script_row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  cfg_idx_t              cfg_index  = CFG_FREEZE;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  sprite_animation_sequencer #(.NUM_SLOTS(SAS_NUM_SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Animation table as the testbench expects it to be.
  // ---------------------------------------------------------------------
  logic [7:0] run_left   [SAS_NUM_SLOTS];
  logic [7:0] dflt_reps  [SAS_NUM_SLOTS];
  int         fr_lo      [SAS_NUM_SLOTS];
  int         fr_hi      [SAS_NUM_SLOTS];
  int         fr_now     [SAS_NUM_SLOTS];
  int         dly_reload [SAS_NUM_SLOTS];
  int         dly_count  [SAS_NUM_SLOTS];
  bit         play_back  [SAS_NUM_SLOTS];
  bit         frozen;
  int         global_dly;

  // Reports still owed by the block, oldest first.
  frame_report_t frames_due[$];

  // Percentages of cycles in which the sender idles or the receiver stalls.
  int tx_idle_pct;
  int rx_stall_pct;

  int errors = 0;
  int n_requests;
  int n_ticks;
  int n_ignored;
  int n_reports = 0;
  int quiet = 0;

  function automatic bit slot_live(int s);
    return run_left[s] != 8'd0 && fr_lo[s] != -1 && fr_hi[s] != -1;
  endfunction

  function automatic frame_report_t make_report(int s, bit live, int frame, bit last);
    frame_report_t r;
    r.slot    = s[5:0];
    r.live    = live;
    r.frame   = live ? frame[15:0] : 16'hFFFF;
    r.repeats = run_left[s];
    r.last    = last;
    return r;
  endfunction

  // One tick of a running slot: count the delay down, or reload it and move
  // the frame one step. Passing the end of the range wraps and spends a
  // repeat, unless the slot runs forever.
  task automatic step_frame(int s);
    bit wrapped;
    wrapped = 1'b0;
    if (dly_count[s] > 0) begin
      dly_count[s]--;
    end else begin
      // A negative counter lands here as well, so the frame moves on that tick.
      dly_count[s] = dly_reload[s] + global_dly - 2;
      if (play_back[s]) begin
        if (fr_now[s] > fr_lo[s]) begin
          fr_now[s]--;
        end else begin
          fr_now[s] = fr_hi[s];
          wrapped = 1'b1;
        end
      end else begin
        if (fr_now[s] < fr_hi[s]) begin
          fr_now[s]++;
        end else begin
          fr_now[s] = fr_lo[s];
          wrapped = 1'b1;
        end
      end
      if (wrapped && run_left[s] != RUN_FOREVER && run_left[s] != 8'd0) begin
        run_left[s]--;
      end
    end
  endtask

  // Applies one accepted request to the expected table and, when keep is
  // set, queues the reports it should produce.
  task automatic animate_request(anim_req_t rq, bit keep);
    int lo;
    int hi;
    int t;
    int shown;
    bit live;
    lo = rq.slot;
    hi = rq.range_end;
    n_requests++;
    if (rq.kind == REQ_TICK) begin
      n_ticks++;
      if (lo > hi) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      if (lo >= SAS_NUM_SLOTS) lo = 0;
      if (hi >= SAS_NUM_SLOTS) hi = SAS_NUM_SLOTS - 1;
      for (int s = lo; s <= hi; s++) begin
        live  = slot_live(s);
        shown = fr_now[s];
        if (live) begin
          if (!frozen) step_frame(s);
        end else begin
          run_left[s] = 8'd0;
        end
        if (keep) frames_due.push_back(make_report(s, live, shown, s == hi));
      end
    end else if (lo >= SAS_NUM_SLOTS) begin
      // A slot beyond the table is simply ignored.
      n_ignored++;
    end else begin
      case (rq.kind)
        REQ_LOAD: begin
          fr_lo[lo]      = $signed(rq.first_fr);
          fr_hi[lo]      = $signed(rq.last_fr);
          dly_reload[lo] = rq.delay;
          dflt_reps[lo]  = rq.repeats;
          fr_now[lo]     = fr_lo[lo];
          dly_count[lo]  = 0;
          run_left[lo]   = 8'd0;
          play_back[lo]  = 1'b0;
        end
        REQ_START: begin
          run_left[lo]  = (rq.repeats != 8'd0) ? rq.repeats : dflt_reps[lo];
          play_back[lo] = rq.reverse;
          fr_now[lo]    = rq.reverse ? fr_hi[lo] : fr_lo[lo];
        end
        default: begin
          run_left[lo] = 8'd0;
        end
      endcase
      if (keep) frames_due.push_back(make_report(lo, slot_live(lo), fr_now[lo], 1'b1));
    end
  endtask

  function automatic anim_req_t mk_req(req_t k, int slot, int range_end = 0, int ff = 0,
                                       int lf = 0, int dly = 0, int reps = 0, bit rev = 0);
    anim_req_t rq;
    rq.kind      = k;
    rq.slot      = slot[5:0];
    rq.range_end = range_end[5:0];
    rq.first_fr  = ff[15:0];
    rq.last_fr   = lf[15:0];
    rq.delay     = dly[14:0];
    rq.repeats   = reps[7:0];
    rq.reverse   = rev;
    return rq;
  endfunction

  function automatic script_row_t scripted(anim_req_t rq, bit typed = 1'b0, bit live = 1'b0,
                                           int frame = -1, int reps = 0);
    script_row_t r;
    r.rq           = rq;
    r.typed        = typed;
    r.want.slot    = rq.slot;
    r.want.live    = live;
    r.want.frame   = frame[15:0];
    r.want.repeats = reps[7:0];
    r.want.last    = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] pick_repeats();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 8'd0;
    if (r < 70) return 8'($urandom_range(5, 1));
    if (r < 85) return RUN_FOREVER;
    return 8'($urandom_range(255));
  endfunction

  // Random requests are mostly well formed: loads of sane frame ranges into
  // a handful of hot slots, starts and ticks over small windows of slots, so
  // that slots actually run, wrap and use up their repeats.
  function automatic anim_req_t random_request();
    anim_req_t rq;
    int roll;
    int r;
    int lo;
    int hi;
    rq.first_fr  = 16'($urandom_range(32767));
    rq.last_fr   = 16'($urandom_range(32767));
    rq.delay     = 15'($urandom_range(32767));
    rq.repeats   = 8'($urandom_range(255));
    rq.reverse   = 1'($urandom_range(1));
    rq.range_end = 6'($urandom_range(63));
    r = $urandom_range(99);
    if (r < 8) rq.slot = 6'($urandom_range(63, SAS_NUM_SLOTS));
    else if (r < 75) rq.slot = 6'($urandom_range(7));
    else rq.slot = 6'($urandom_range(SAS_NUM_SLOTS - 1));
    roll = $urandom_range(99);
    if (roll < 20) begin
      rq.kind = REQ_LOAD;
      case ($urandom_range(9))
        0: begin
          rq.first_fr = -16'sd1;
          rq.last_fr  = 16'($urandom_range(20));
        end
        1: begin
          rq.first_fr = 16'($urandom_range(20));
          rq.last_fr  = -16'sd1;
        end
        2: ;  // Frame numbers anywhere in their range.
        3: begin
          // Range given backwards.
          rq.first_fr = 16'($urandom_range(20, 10));
          rq.last_fr  = 16'($urandom_range(9));
        end
        default: begin
          lo = $urandom_range(40);
          rq.first_fr = lo[15:0];
          rq.last_fr  = 16'(lo + $urandom_range(5));
        end
      endcase
      r = $urandom_range(99);
      if (r < 70) rq.delay = 15'($urandom_range(3));
      else if (r < 90) rq.delay = 15'($urandom_range(15));
      rq.repeats = pick_repeats();
    end else if (roll < 40) begin
      rq.kind    = REQ_START;
      rq.repeats = pick_repeats();
    end else if (roll < 48) begin
      rq.kind = REQ_STOP;
    end else begin
      rq.kind = REQ_TICK;
      if ($urandom_range(99) >= 15) begin
        lo = ($urandom_range(99) < 70) ? $urandom_range(7) : $urandom_range(SAS_NUM_SLOTS - 1);
        hi = lo + $urandom_range(7);
        if ($urandom_range(1)) begin
          rq.slot      = hi[5:0];
          rq.range_end = lo[5:0];
        end else begin
          rq.slot      = lo[5:0];
          rq.range_end = hi[5:0];
        end
      end else begin
        rq.slot = 6'($urandom_range(63));
      end
    end
    return rq;
  endfunction

  // Offers one request on the input channel and returns at the rising edge
  // where the transaction completes. Called at a falling edge.
  task automatic send_request(anim_req_t rq);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rq.kind;
    in_tdata  <= {4'b0, rq.reverse, rq.repeats, rq.delay, rq.last_fr, rq.first_fr,
                  rq.range_end, rq.slot};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops offering requests and waits until the block has delivered every
  // report and has had time to finish work that produces none.
  task automatic drain_block();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (frames_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One phase of random traffic under one register setting and idle mix.
  task automatic run_phase(bit frz, int gdly, int idle_pct, int stall_pct, int count,
                           bit pause_midway);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FREEZE;
    cfg_wdata <= {15'b0, frz};
    @(negedge clk);
    cfg_index <= CFG_GDELAY;
    cfg_wdata <= gdly[15:0];
    @(negedge clk);
    cfg_we       <= 1'b0;
    frozen       = frz;
    global_dly   = gdly;
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      anim_req_t rq;
      if (pause_midway && i == count / 2) begin
        // Hold off until the block has caught up completely.
        in_tvalid <= 1'b0;
        @(negedge clk);
        while (frames_due.size() != 0) @(negedge clk);
      end
      rq = random_request();
      send_request(rq);
      animate_request(rq, 1'b1);
      @(negedge clk);
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: stalls at random and checks every report transaction against
  // the oldest expectation.
  // ---------------------------------------------------------------------
  frame_report_t seen;
  frame_report_t want;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic note_mismatch(string what, frame_report_t w, frame_report_t g);
    errors++;
    if (errors <= 10) begin
      $display("%s at %0t", what, $time);
      $display("  expected slot %0d live %0b frame %0d repeats %0d last %0b",
               w.slot, w.live, w.frame, w.repeats, w.last);
      $display("  actual   slot %0d live %0b frame %0d repeats %0d last %0b",
               g.slot, g.live, g.frame, g.repeats, g.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.slot    = out_tdata[5:0];
      seen.live    = out_tdata[6];
      seen.frame   = out_tdata[22:7];
      seen.repeats = out_tdata[30:23];
      seen.last    = out_tlast;
      n_reports++;
      if (frames_due.size() == 0) begin
        note_mismatch("Report with nothing expected", seen, seen);
      end else begin
        want = frames_due.pop_front();
        if (seen.slot !== want.slot || seen.live !== want.live
            || seen.frame !== want.frame || seen.repeats !== want.repeats
            || seen.last !== want.last) begin
          note_mismatch("Report mismatch", want, seen);
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  script_row_t script[$];

  initial begin
    n_requests   = 0;
    n_ticks      = 0;
    n_ignored    = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    frozen       = 1'b0;
    global_dly   = 2;
    for (int s = 0; s < SAS_NUM_SLOTS; s++) begin
      run_left[s]   = 8'd0;
      dflt_reps[s]  = 8'd0;
      fr_lo[s]      = -1;
      fr_hi[s]      = 0;
      fr_now[s]     = 0;
      dly_reload[s] = 0;
      dly_count[s]  = 0;
      play_back[s]  = 1'b0;
    end

    // Directed script, run at the reset register values with no idling.
    // Every slot is idle right after reset.
    script.push_back(scripted(mk_req(REQ_TICK, 0, 31)));
    script.push_back(scripted(mk_req(REQ_STOP, 5), 1, 0, -1, 0));
    // Slot 0: frames 0..1, no delay, two repeats by default. It wraps on
    // the second tick and spends one repeat.
    script.push_back(scripted(mk_req(REQ_LOAD, 0, 0, 0, 1, 0, 2), 1, 0, -1, 0));
    script.push_back(scripted(mk_req(REQ_START, 0, 0, 0, 0, 0, 0, 0), 1, 1, 0, 2));
    script.push_back(scripted(mk_req(REQ_TICK, 0, 0)));
    script.push_back(scripted(mk_req(REQ_TICK, 0, 0)));
    // Last slot at the top of every field, running backwards forever.
    script.push_back(scripted(mk_req(REQ_LOAD, 31, 0, 32767, 32767, 32767, 255),
                              1, 0, -1, 0));
    script.push_back(scripted(mk_req(REQ_START, 31, 0, 0, 0, 0, 255, 1), 1, 1, 32767, 255));
    // Reversed bounds with the upper one beyond the table.
    script.push_back(scripted(mk_req(REQ_TICK, 63, 31)));
    // Unused first frame: started but never active, so a tick clears it.
    script.push_back(scripted(mk_req(REQ_LOAD, 1, 0, -1, 5, 1, 7), 1, 0, -1, 0));
    script.push_back(scripted(mk_req(REQ_START, 1, 0, 0, 0, 0, 3, 0), 1, 0, -1, 3));
    script.push_back(scripted(mk_req(REQ_TICK, 1, 0)));
    // Unused last frame.
    script.push_back(scripted(mk_req(REQ_LOAD, 2, 0, 4, -1, 2, 1), 1, 0, -1, 0));
    // Slot 3 plays 12 down to 10 with one tick of delay between frames.
    script.push_back(scripted(mk_req(REQ_LOAD, 3, 0, 10, 12, 1, 1), 1, 0, -1, 0));
    script.push_back(scripted(mk_req(REQ_START, 3, 0, 0, 0, 0, 0, 1), 1, 1, 12, 1));
    script.push_back(scripted(mk_req(REQ_TICK, 2, 3)));
    script.push_back(scripted(mk_req(REQ_TICK, 3, 3)));
    script.push_back(scripted(mk_req(REQ_TICK, 3, 3)));
    script.push_back(scripted(mk_req(REQ_STOP, 3), 1, 0, -1, 0));
    // Requests aimed past the table produce nothing at all.
    script.push_back(scripted(mk_req(REQ_LOAD, 40, 0, 3, 4, 0, 1), 1));
    script.push_back(scripted(mk_req(REQ_START, 63, 0, 0, 0, 0, 1), 1));
    script.push_back(scripted(mk_req(REQ_STOP, 32), 1));
    // Both bounds beyond the table: the whole table is ticked.
    script.push_back(scripted(mk_req(REQ_TICK, 50, 40)));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      send_request(script[i].rq);
      animate_request(script[i].rq, !script[i].typed);
      if (script[i].typed && script[i].rq.slot < SAS_NUM_SLOTS) begin
        frames_due.push_back(script[i].want);
      end
      @(negedge clk);
    end

    // Random phases: each one rewrites both registers first. The sender
    // pauses for a full drain halfway through the third phase.
    run_phase(1'b0, 2,      0,  0,  56, 1'b0);
    run_phase(1'b0, 0,      61, 0,  56, 1'b0);
    run_phase(1'b0, 1,      0,  61, 56, 1'b1);
    run_phase(1'b0, 32767,  18, 18, 56, 1'b0);
    run_phase(1'b0, -32766, 0,  0,  56, 1'b0);
    run_phase(1'b1, 3,      18, 18, 56, 1'b0);

    drain_block();

    $display("Covered %0d requests (%0d ticks, %0d aimed past the table), %0d reports checked",
             n_requests, n_ticks, n_ignored, n_reports);
    $display("Freeze on and off, global delay from -32766 to 32767, idle and stall mixes");
    if (errors == 0 && frames_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
